// ===== hw/rtl/nsr_pkg.sv =====
// shared constants, state and command types for the newton square root block
`timescale 1ns / 1ps

package nsr_pkg;

    // field widths
    localparam int VAL_W     = 32;
    localparam int EPS_W     = 31;
    localparam int ROOT_W    = 24;
    localparam int FRAC_W    = 16;

    // iteration cap
    localparam int MAX_STEPS = 32;

    // scaled operand, quotient and guess width
    localparam int Q_W       = VAL_W - 1 + FRAC_W;
    localparam int DCNT_W    = $clog2(Q_W);
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
    localparam logic [VAL_W-1:0]  ONE_Q    = VAL_W'(64'd1 << FRAC_W);
    localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_UPDATE,
        ST_CHECK,
        ST_FINISH
    } nsr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic advance;
        logic set_capped;
        logic res_load;
    } nsr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic special;
        logic div_done;
        logic converged;
        logic out_busy;
    } nsr_status_t;

endpackage

// ===== hw/rtl/newton_square_root_top.sv =====
// top level of the newton square root block
//
//  channel   signals                         width        direction
//  input     in_valid in_ready value         32 signed    in
//  output    out_valid out_ready root        24 unsigned  out
//            invalid capped                  1 each       out
//  config    cfg_valid cfg_ready cfg_data    31 unsigned  in (epsilon)
//
// one item at a time: accept, a classify state, then per newton step the serial
// restoring divider plus update and check, for at most 32 newton steps; negative,
// zero and one items go from classify straight to finish.
// every newton step uses the single shared serial divider.
// asynchronous active-low reset clears the controller, output valid and epsilon (1).
// a new item is taken while the previous result waits in the output register;
// a finished result holds in the datapath until that register frees.
`timescale 1ns / 1ps

module newton_square_root_top
    import nsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VAL_W-1:0]   value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ROOT_W-1:0]  root,
    output logic               invalid,
    output logic               capped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [EPS_W-1:0]   cfg_data
);

    nsr_cmd_t    cmd;
    nsr_status_t status;

    // tolerance writes are always taken
    assign cfg_ready = 1'b1;

    nsr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nsr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .root      (root),
        .invalid   (invalid),
        .capped    (capped),
        .out_valid (out_valid)
    );

endmodule

// ===== hw/rtl/nsr_datapath.sv =====
// datapath: operand registers, serial divider, newton update and output register
`timescale 1ns / 1ps

module nsr_datapath
    import nsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VAL_W-1:0]   value,
    input  logic               cfg_valid,
    input  logic [EPS_W-1:0]   cfg_data,
    input  nsr_cmd_t           cmd,
    output nsr_status_t        status,
    input  logic               out_ready,
    output logic [ROOT_W-1:0]  root,
    output logic               invalid,
    output logic               capped,
    output logic               out_valid
);

    logic [EPS_W-1:0]  eps_reg;
    logic [Q_W-1:0]    num_reg;
    logic [Q_W-1:0]    last_reg;
    logic [Q_W-1:0]    next_reg;
    logic [Q_W-1:0]    rem_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              neg_reg;
    logic              triv_reg;
    logic              cap_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              invalid_reg;
    logic              capped_reg;
    logic              out_valid_reg;

    logic [Q_W:0]      rem_shift;
    logic [Q_W:0]      div_sub;
    logic              div_fit;
    logic [Q_W-1:0]    rem_next;
    logic [Q_W-1:0]    quo_next;
    logic [Q_W:0]      guess_sum;
    logic [Q_W-1:0]    next_next;
    logic [Q_W-1:0]    diff;
    logic [ROOT_W-1:0] root_next;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RST;
        end
        else if (cfg_valid)
        begin
            eps_reg <= cfg_data;
        end
    end

    // one restoring division step: quotient bits shift in from the right
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[Q_W-1]};
        div_sub   = rem_shift - {1'b0, last_reg};
        div_fit   = rem_shift >= {1'b0, last_reg};
        if (div_fit)
        begin
            rem_next = div_sub[Q_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[Q_W-1:0];
        end
        quo_next = {quo_reg[Q_W-2:0], div_fit};
    end

    // newton update: floor of the mean of guess and quotient
    always_comb
    begin
        guess_sum = {1'b0, last_reg} + {1'b0, quo_reg};
        next_next = guess_sum[Q_W:1];
    end

    // convergence test on the change of guess
    always_comb
    begin
        if (last_reg > next_reg)
        begin
            diff = last_reg - next_reg;
        end
        else
        begin
            diff = next_reg - last_reg;
        end
    end

    // result selection with saturation of wide roots
    always_comb
    begin
        priority if (neg_reg)
        begin
            root_next = '0;
        end
        else if (triv_reg)
        begin
            root_next = last_reg[ROOT_W-1:0];
        end
        else if (next_reg > Q_W'(ROOT_MAX))
        begin
            root_next = ROOT_MAX;
        end
        else
        begin
            root_next = next_reg[ROOT_W-1:0];
        end
    end

    // operand, guess and divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg  <= {value[VAL_W-2:0], FRAC_W'(0)};
            last_reg <= Q_W'(value[VAL_W-2:0]);
            neg_reg  <= value[VAL_W-1];
            triv_reg <= (value == '0) || (value == ONE_Q);
            cap_reg  <= 1'b0;
        end
        if (cmd.advance)
        begin
            last_reg <= next_reg;
        end
        if (cmd.set_capped)
        begin
            cap_reg <= 1'b1;
        end
        if (cmd.update)
        begin
            next_reg <= next_next;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            quo_reg  <= num_reg;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            root_reg    <= root_next;
            invalid_reg <= neg_reg;
            capped_reg  <= cap_reg && !neg_reg && !triv_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.special   = neg_reg || triv_reg;
        status.div_done  = dcnt_reg == DCNT_W'(Q_W - 1);
        status.converged = diff <= Q_W'(eps_reg);
        status.out_busy  = out_valid_reg && !out_ready;
    end

    assign root      = root_reg;
    assign invalid   = invalid_reg;
    assign capped    = capped_reg;
    assign out_valid = out_valid_reg;

    // a negative operand gives a zero root and no cap flag
    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> root_reg == '0 && !capped_reg)
        else $error("invalid item with nonzero root or cap flag");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over a waiting item");

    // divider never steps past its last quotient bit
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && status.div_done |=> !cmd.div_step)
        else $error("divider stepped past its last bit");

endmodule

// ===== hw/rtl/nsr_controller.sv =====
// controller: sequences load, serial division, update and convergence check
`timescale 1ns / 1ps

module nsr_controller
    import nsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  nsr_status_t status,
    output nsr_cmd_t    cmd
);

    nsr_state_t        state_reg;
    nsr_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // state and step count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                step_next = '0;
                if (status.special)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                step_next  = step_reg + STEP_W'(1);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (status.converged)
                begin
                    state_next = ST_FINISH;
                end
                else if (step_reg >= STEP_W'(MAX_STEPS))
                begin
                    cmd.set_capped = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    cmd.advance  = 1'b1;
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the newton square root block
`timescale 1ns / 1ps

module testbench
    import nsr_pkg::*;
;

    // timing figures; the latency bound is taken from the block's step count
    localparam int MAX_LATENCY = 3 + 49 * MAX_STEPS;
    localparam int LONG_HOLD   = 6000;
    localparam int CYCLE_LIMIT = 20_000_000;

    localparam logic [EPS_W-1:0] EPS_MAX = '1;

    // directed operands, run with the reset tolerance
    localparam logic [VAL_W-1:0] EDGE_VALUES [14] = '{
        32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0002,
        32'h0000_FFFF, 32'h0001_0001, 32'h0004_0000, 32'h0002_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
        32'h2AAA_AAAA, 32'h0064_0000
    };

    // directed operands for a zero tolerance
    localparam logic [VAL_W-1:0] ZERO_EPS_VALUES [5] = '{
        32'h0002_0000, 32'h7FFF_FFFF, 32'h0000_0003, 32'h0001_0000, 32'hFFFF_0000
    };

    // directed operands for the widest tolerance, two of them with saturating roots
    localparam logic [VAL_W-1:0] WIDE_EPS_VALUES [5] = '{
        32'h7FFF_FFFF, 32'h4000_0000, 32'h0000_0001, 32'h0000_0000, 32'h8000_0001
    };

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              invalid;
        logic              capped;
    } root_item_t;

    // predicts each root and compares it against what the block returns
    class sqrt_scoreboard;
        logic [EPS_W-1:0] epsilon;
        root_item_t       expected_roots[$];
        int unsigned      mismatches;
        int unsigned      accepted;
        int unsigned      n_invalid;
        int unsigned      n_capped;
        int unsigned      n_saturated;

        function new();
            epsilon     = EPS_RST;
            mismatches  = 0;
            accepted    = 0;
            n_invalid   = 0;
            n_capped    = 0;
            n_saturated = 0;
        endfunction

        function void set_epsilon(input logic [EPS_W-1:0] eps);
            epsilon = eps;
        endfunction

        // one newton step, halving each term so the sum cannot overflow
        function logic [63:0] newton_step(input logic [63:0] scaled, input logic [63:0] guess);
            logic [63:0] quot;
            if (guess == 64'd0)
                quot = {1'b0, {63{1'b1}}};
            else
                quot = scaled / guess;
            return (guess >> 1) + (quot >> 1) + ((64'(guess[0]) + 64'(quot[0])) >> 1);
        endfunction

        function root_item_t newton_root(input logic [VAL_W-1:0] v);
            root_item_t  res;
            logic [63:0] scaled;
            logic [63:0] guess_old;
            logic [63:0] guess_new;
            logic [63:0] diff;
            int          steps;
            bit          done;
            res = '0;
            if (v[VAL_W-1]) begin
                res.invalid = 1'b1;
                return res;
            end
            if (v == '0 || v == ONE_Q) begin
                res.root = ROOT_W'(v);
                return res;
            end
            scaled    = 64'(v) << FRAC_W;
            guess_old = 64'(v);
            guess_new = newton_step(scaled, guess_old);
            steps     = 1;
            done      = 1'b0;
            while (!done) begin
                diff = (guess_old > guess_new) ? guess_old - guess_new : guess_new - guess_old;
                if (diff <= 64'(epsilon)) begin
                    done = 1'b1;
                end
                else if (steps >= MAX_STEPS) begin
                    res.capped = 1'b1;
                    done       = 1'b1;
                end
                else begin
                    guess_old = guess_new;
                    guess_new = newton_step(scaled, guess_old);
                    steps++;
                end
            end
            res.root = (guess_new > 64'(ROOT_MAX)) ? ROOT_MAX : guess_new[ROOT_W-1:0];
            return res;
        endfunction

        function void note_value(input logic [VAL_W-1:0] v);
            root_item_t res;
            res = newton_root(v);
            expected_roots.push_back(res);
            accepted++;
            if (res.invalid)
                n_invalid++;
            if (res.capped)
                n_capped++;
            if (!res.invalid && res.root == ROOT_MAX)
                n_saturated++;
        endfunction

        function void check_result(input logic [ROOT_W-1:0] r, input logic inv,
                                   input logic cap);
            root_item_t exp_item;
            if (expected_roots.size() == 0) begin
                $error("unexpected result: root %0d invalid %0d capped %0d", r, inv, cap);
                mismatches++;
                return;
            end
            exp_item = expected_roots.pop_front();
            if (r !== exp_item.root) begin
                $error("root mismatch: expected %0d, actual %0d", exp_item.root, r);
                mismatches++;
            end
            if (inv !== exp_item.invalid) begin
                $error("invalid mismatch: expected %0d, actual %0d", exp_item.invalid, inv);
                mismatches++;
            end
            if (cap !== exp_item.capped) begin
                $error("capped mismatch: expected %0d, actual %0d", exp_item.capped, cap);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_roots.size();
        endfunction

        function void check_leftover();
            if (expected_roots.size() != 0) begin
                $error("%0d expected roots never arrived", expected_roots.size());
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [VAL_W-1:0]  value     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ROOT_W-1:0] root;
    logic              invalid;
    logic              capped;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [EPS_W-1:0]  cfg_data  = '0;

    sqrt_scoreboard sb;
    int unsigned    hold_requests = 0;
    int unsigned    holds_served  = 0;
    int unsigned    eps_settings  = 1;
    int unsigned    cycles        = 0;

    newton_square_root_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root),
        .invalid   (invalid),
        .capped    (capped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // idle lengths: mostly none or short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 5);
        if (r < 98)
            return $urandom_range(6, 60);
        return $urandom_range(200, 1500);
    endfunction

    // operand mix: negatives, zero and one, tiny, mid-size and full range
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 32'($urandom) | 32'h8000_0000;
        if (r < 16)
            return ($urandom_range(0, 1) == 0) ? '0 : ONE_Q;
        if (r < 26)
            return 32'($urandom_range(1, 16));
        if (r < 50)
            return 32'($urandom_range(1, 32'h00FF_FFFF));
        return 32'($urandom) & 32'h7FFF_FFFF;
    endfunction

    // offer one item, after an optional gap, and wait for acceptance
    task automatic send_value(input logic [VAL_W-1:0] v, input int unsigned gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_value(v);
    endtask

    // stop offering and wait for every outstanding root
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // write the tolerance register, block idle
    task automatic write_epsilon(input logic [EPS_W-1:0] eps);
        cfg_valid <= 1'b1;
        cfg_data  <= eps;
        do @(posedge clk); while (!cfg_ready);
        sb.set_epsilon(eps);
        eps_settings++;
        cfg_valid <= 1'b0;
    endtask

    // one tolerance setting with random operands; pauses halfway to let the block drain
    task automatic run_random_phase(input logic [EPS_W-1:0] eps, input int unsigned count,
                                    input bit long_hold);
        drain_results();
        write_epsilon(eps);
        for (int unsigned i = 0; i < count; i++) begin
            if (long_hold && i == 10)
                hold_requests++;
            if (i == count / 2)
                drain_results();
            send_value(pick_value(), idle_len());
        end
    endtask

    // result side: random stalls after each item, long hold on request
    initial
    begin : result_sink
        int unsigned stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                sb.check_result(root, invalid, capped);
                stall = idle_len();
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // cycle limit
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic [EPS_W-1:0] eps;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset tolerance, then zero, then the widest
        foreach (EDGE_VALUES[i])
            send_value(EDGE_VALUES[i], 0);
        drain_results();
        write_epsilon('0);
        foreach (ZERO_EPS_VALUES[i])
            send_value(ZERO_EPS_VALUES[i], 0);
        drain_results();
        write_epsilon(EPS_MAX);
        foreach (WIDE_EPS_VALUES[i])
            send_value(WIDE_EPS_VALUES[i], 0);

        // random phases across tolerance settings
        run_random_phase(EPS_W'(1), 200, 1'b1);
        run_random_phase('0, 80, 1'b0);
        run_random_phase(EPS_MAX, 150, 1'b0);
        run_random_phase(EPS_W'($urandom_range(2, 255)), 200, 1'b0);
        eps = EPS_W'($urandom);
        if (eps == '0)
            eps = EPS_W'(1);
        run_random_phase(eps, 150, 1'b0);
        run_random_phase(EPS_W'($urandom_range(256, 65535)), 150, 1'b1);

        // wind down
        drain_results();
        repeat (MAX_LATENCY) @(posedge clk);
        sb.check_leftover();

        $display("covered %0d operands over %0d tolerance settings", sb.accepted, eps_settings);
        $display("negative %0d, capped %0d, saturated %0d, mismatches %0d",
                 sb.n_invalid, sb.n_capped, sb.n_saturated, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
